/* rtl/core/ssl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ssl_pkg
// Shared types, token kinds and helpers for the script source lexer.
// ----------------------------------------------------------------------------
package ssl_pkg;

  localparam int unsigned PosWidth  = 32;
  localparam int unsigned LineWidth = 24;
  localparam int unsigned LenWidth  = 16;
  localparam int unsigned PrefixLen = 6;

  typedef enum logic [2:0] {
    ModeIdle    = 3'd0,
    ModeOp      = 3'd1,
    ModeComment = 3'd2,
    ModeString  = 3'd3,
    ModeIdent   = 3'd4,
    ModeNum     = 3'd5,
    ModeNumDot  = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    ErrUntermString = 2'd0,
    ErrBadNumber    = 2'd1,
    ErrBadChar      = 2'd2
  } err_e;

  localparam logic [5:0] KindLParen  = 6'd0;
  localparam logic [5:0] KindRParen  = 6'd1;
  localparam logic [5:0] KindLBrace  = 6'd2;
  localparam logic [5:0] KindRBrace  = 6'd3;
  localparam logic [5:0] KindComma   = 6'd4;
  localparam logic [5:0] KindDot     = 6'd5;
  localparam logic [5:0] KindMinus   = 6'd6;
  localparam logic [5:0] KindPlus    = 6'd7;
  localparam logic [5:0] KindSemi    = 6'd8;
  localparam logic [5:0] KindSlash   = 6'd9;
  localparam logic [5:0] KindStar    = 6'd10;
  localparam logic [5:0] KindBang    = 6'd11;
  localparam logic [5:0] KindEqual   = 6'd13;
  localparam logic [5:0] KindGreater = 6'd15;
  localparam logic [5:0] KindLess    = 6'd17;
  localparam logic [5:0] KindIdent   = 6'd19;
  localparam logic [5:0] KindString  = 6'd20;
  localparam logic [5:0] KindNumber  = 6'd21;
  localparam logic [5:0] KindAnd     = 6'd22;
  localparam logic [5:0] KindClass   = 6'd23;
  localparam logic [5:0] KindElse    = 6'd24;
  localparam logic [5:0] KindFalse   = 6'd25;
  localparam logic [5:0] KindFor     = 6'd26;
  localparam logic [5:0] KindFun     = 6'd27;
  localparam logic [5:0] KindIf      = 6'd28;
  localparam logic [5:0] KindNil     = 6'd29;
  localparam logic [5:0] KindOr      = 6'd30;
  localparam logic [5:0] KindPrint   = 6'd31;
  localparam logic [5:0] KindReturn  = 6'd32;
  localparam logic [5:0] KindSuper   = 6'd33;
  localparam logic [5:0] KindThis    = 6'd34;
  localparam logic [5:0] KindTrue    = 6'd35;
  localparam logic [5:0] KindVar     = 6'd36;
  localparam logic [5:0] KindWhile   = 6'd37;
  localparam logic [5:0] KindError   = 6'd38;
  localparam logic [5:0] KindEof     = 6'd39;
  localparam logic [5:0] KindNone    = 6'd63;

  typedef logic [7:0] char_t;
  typedef char_t [PrefixLen-1:0] prefix_t;

  function automatic logic is_alpha(input char_t b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic logic is_digit(input char_t b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_space(input char_t b);
    return b == " " || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic [5:0] single_kind(input char_t b);
    logic [5:0] k;
    case (b)
      "(":     k = KindLParen;
      ")":     k = KindRParen;
      "{":     k = KindLBrace;
      "}":     k = KindRBrace;
      ",":     k = KindComma;
      ".":     k = KindDot;
      "-":     k = KindMinus;
      "+":     k = KindPlus;
      ";":     k = KindSemi;
      "*":     k = KindStar;
      default: k = KindNone;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] op_kind(input char_t b);
    logic [5:0] k;
    case (b)
      "/":     k = KindSlash;
      "!":     k = KindBang;
      "=":     k = KindEqual;
      ">":     k = KindGreater;
      default: k = KindLess;
    endcase
    return k;
  endfunction

  // prefix entry i holds character i of the word
  function automatic logic [5:0] word_kind(input prefix_t w, input logic [2:0] n);
    logic [5:0] k;
    k = KindIdent;
    case (n)
      3'd2: begin
        if (w[0] == "i" && w[1] == "f") k = KindIf;
        if (w[0] == "o" && w[1] == "r") k = KindOr;
      end
      3'd3: begin
        if (w[0] == "a" && w[1] == "n" && w[2] == "d") k = KindAnd;
        if (w[0] == "f" && w[1] == "o" && w[2] == "r") k = KindFor;
        if (w[0] == "f" && w[1] == "u" && w[2] == "n") k = KindFun;
        if (w[0] == "n" && w[1] == "i" && w[2] == "l") k = KindNil;
        if (w[0] == "v" && w[1] == "a" && w[2] == "r") k = KindVar;
      end
      3'd4: begin
        if (w[0] == "e" && w[1] == "l" && w[2] == "s" && w[3] == "e") k = KindElse;
        if (w[0] == "t" && w[1] == "h" && w[2] == "i" && w[3] == "s") k = KindThis;
        if (w[0] == "t" && w[1] == "r" && w[2] == "u" && w[3] == "e") k = KindTrue;
      end
      3'd5: begin
        if (w[0] == "c" && w[1] == "l" && w[2] == "a" && w[3] == "s" && w[4] == "s")
          k = KindClass;
        if (w[0] == "f" && w[1] == "a" && w[2] == "l" && w[3] == "s" && w[4] == "e")
          k = KindFalse;
        if (w[0] == "p" && w[1] == "r" && w[2] == "i" && w[3] == "n" && w[4] == "t")
          k = KindPrint;
        if (w[0] == "s" && w[1] == "u" && w[2] == "p" && w[3] == "e" && w[4] == "r")
          k = KindSuper;
        if (w[0] == "w" && w[1] == "h" && w[2] == "i" && w[3] == "l" && w[4] == "e")
          k = KindWhile;
      end
      3'd6: begin
        if (w[0] == "r" && w[1] == "e" && w[2] == "t" && w[3] == "u" && w[4] == "r" &&
            w[5] == "n") k = KindReturn;
      end
      default: k = KindIdent;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/script_source_lexer.sv */
`default_nettype none
// output: the tokens of an accepted byte are registered in the output buffer and
// shown from its head in the cycle after; a two-token byte presents them in order
// throughput: one byte per cycle while the output buffer has room; a two-token
// byte holds input ready low while the second token drains from the output buffer
// reset: scanner idle, position and length zero, line one, buffer empty
// ----------------------------------------------------------------------------
// script_source_lexer
// Streaming scanner: one source byte in, zero to two tokens out.
// ----------------------------------------------------------------------------
module script_source_lexer #(
  parameter int unsigned POS_WIDTH  = ssl_pkg::PosWidth,
  parameter int unsigned LINE_WIDTH = ssl_pkg::LineWidth,
  parameter int unsigned LEN_WIDTH  = ssl_pkg::LenWidth
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  src_valid_i,
  output      logic                  src_ready_o,
  input  wire logic [7:0]            src_byte_i,
  output      logic                  tok_valid_o,
  input  wire logic                  tok_ready_i,
  output      logic [5:0]            tok_kind_o,
  output      logic [POS_WIDTH-1:0]  tok_start_o,
  output      logic [LEN_WIDTH-1:0]  tok_length_o,
  output      logic [LINE_WIDTH-1:0] tok_line_o,
  output      logic [1:0]            err_code_o,
  output      logic                  last_of_run_o
);

  typedef struct packed {
    logic [5:0]            kind;
    logic [POS_WIDTH-1:0]  start;
    logic [LEN_WIDTH-1:0]  len;
    logic [LINE_WIDTH-1:0] line;
    logic [1:0]            err;
  } tok_t;

  localparam logic [POS_WIDTH-1:0]  PosMax  = '1;
  localparam logic [LINE_WIDTH-1:0] LineMax = '1;
  localparam logic [LEN_WIDTH-1:0]  LenMax  = '1;

  ssl_pkg::mode_e         mode_q, mode_d;
  ssl_pkg::char_t         pend_q, pend_d;
  logic [POS_WIDTH-1:0]   pos_q, pos_d, begin_q, begin_d;
  logic [LINE_WIDTH-1:0]  line_q, line_d;
  logic [LEN_WIDTH-1:0]   len_q, len_d;
  ssl_pkg::prefix_t       prefix_q, prefix_d;

  // two-entry output buffer, entry 0 is the head
  tok_t                   buf_q [2];
  logic [1:0]             last_q;
  logic [1:0]             cnt_q;

  tok_t                   t0, t1;
  logic                   e0, e1;
  logic                   accept, pop;

  logic [7:0]             b;
  logic                   again;
  ssl_pkg::mode_e         mode_a;
  logic [LINE_WIDTH-1:0]  line_a;
  logic [LINE_WIDTH-1:0]  line_inc;
  logic [LEN_WIDTH-1:0]   len_inc;
  logic [5:0]             sk;

  assign b        = src_byte_i;
  assign accept   = src_valid_i && src_ready_o;
  assign pop      = tok_valid_o && tok_ready_i;
  assign line_inc = (line_q != LineMax) ? line_q + 1'b1 : line_q;
  assign len_inc  = (len_q != LenMax) ? len_q + 1'b1 : len_q;
  assign sk       = ssl_pkg::single_kind(b);

  // input stalls only if a push might not fit
  assign src_ready_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

  always_comb begin
    mode_d   = mode_q;
    pend_d   = pend_q;
    pos_d    = (pos_q != PosMax) ? pos_q + 1'b1 : pos_q;
    begin_d  = begin_q;
    line_d   = line_q;
    len_d    = len_q;
    prefix_d = prefix_q;
    e0       = 1'b0;
    e1       = 1'b0;
    t0       = '0;
    t1       = '0;
    again    = 1'b0;

    // first pass: continue the token in progress
    case (mode_q)
      ssl_pkg::ModeOp: begin
        mode_d = ssl_pkg::ModeIdle;
        if (pend_q == "/" && b == "/") begin
          mode_d = ssl_pkg::ModeComment;
        end else if (pend_q != "/" && b == "=") begin
          e0 = 1'b1;
          t0 = '{ssl_pkg::op_kind(pend_q) + 6'd1, begin_q, LEN_WIDTH'(2), line_q, 2'd0};
        end else begin
          e0 = 1'b1;
          t0 = '{ssl_pkg::op_kind(pend_q), begin_q, LEN_WIDTH'(1), line_q, 2'd0};
          again = 1'b1;
        end
      end
      ssl_pkg::ModeComment: begin
        if (b == 8'd10) begin
          line_d = line_inc;
          mode_d = ssl_pkg::ModeIdle;
        end else if (b == 8'd0) begin
          mode_d = ssl_pkg::ModeIdle;
          again  = 1'b1;
        end
      end
      ssl_pkg::ModeString: begin
        if (b == "\"") begin
          e0 = 1'b1;
          t0 = '{ssl_pkg::KindString, begin_q, len_q, line_q, 2'd0};
          mode_d = ssl_pkg::ModeIdle;
        end else if (b == 8'd0) begin
          e0 = 1'b1;
          t0 = '{ssl_pkg::KindError, '0, '0, line_q, ssl_pkg::ErrUntermString};
          mode_d = ssl_pkg::ModeIdle;
          again  = 1'b1;
        end else begin
          if (b == 8'd10) line_d = line_inc;
          len_d = len_inc;
        end
      end
      ssl_pkg::ModeIdent: begin
        if (ssl_pkg::is_alpha(b) || ssl_pkg::is_digit(b)) begin
          for (int i = 0; i < ssl_pkg::PrefixLen; i++) begin
            if (len_q == LEN_WIDTH'(i)) prefix_d[i] = b;
          end
          len_d = len_inc;
        end else begin
          e0 = 1'b1;
          t0 = '{(len_q > LEN_WIDTH'(6)) ? ssl_pkg::KindIdent
                 : ssl_pkg::word_kind(prefix_q, len_q[2:0]),
                 begin_q, len_q, line_q, 2'd0};
          mode_d = ssl_pkg::ModeIdle;
          again  = 1'b1;
        end
      end
      ssl_pkg::ModeNum, ssl_pkg::ModeNumDot: begin
        if (ssl_pkg::is_digit(b)) begin
          len_d = len_inc;
        end else if (b == ".") begin
          if (mode_q == ssl_pkg::ModeNumDot) begin
            e0 = 1'b1;
            t0 = '{ssl_pkg::KindError, '0, '0, line_q, ssl_pkg::ErrBadNumber};
            mode_d = ssl_pkg::ModeIdle;
          end else begin
            len_d  = len_inc;
            mode_d = ssl_pkg::ModeNumDot;
          end
        end else begin
          e0 = 1'b1;
          t0 = '{ssl_pkg::KindNumber, begin_q, len_q, line_q, 2'd0};
          mode_d = ssl_pkg::ModeIdle;
          again  = 1'b1;
        end
      end
      default: begin
        mode_d = ssl_pkg::ModeIdle;
        again  = 1'b1;
      end
    endcase

    // second pass: scan the byte from idle; line is not touched by pass one here
    mode_a = mode_d;
    line_a = line_q;
    if (again) begin
      if (ssl_pkg::is_space(b)) begin
        if (b == 8'd10) line_d = line_inc;
      end else if (b == 8'd0) begin
        e1     = 1'b1;
        t1     = '{ssl_pkg::KindEof, pos_q, '0, line_a, 2'd0};
        pos_d  = '0;
        line_d = LINE_WIDTH'(1);
        mode_a = ssl_pkg::ModeIdle;
      end else if (sk != ssl_pkg::KindNone) begin
        e1 = 1'b1;
        t1 = '{sk, pos_q, LEN_WIDTH'(1), line_a, 2'd0};
      end else if (b == "!" || b == "<" || b == ">" || b == "=" || b == "/") begin
        mode_a  = ssl_pkg::ModeOp;
        pend_d  = b;
        begin_d = pos_q;
      end else if (b == "\"") begin
        mode_a  = ssl_pkg::ModeString;
        begin_d = pos_q + 1'b1;
        len_d   = '0;
      end else if (ssl_pkg::is_alpha(b)) begin
        mode_a      = ssl_pkg::ModeIdent;
        begin_d     = pos_q;
        len_d       = LEN_WIDTH'(1);
        prefix_d[0] = b;
      end else if (ssl_pkg::is_digit(b)) begin
        mode_a  = ssl_pkg::ModeNum;
        begin_d = pos_q;
        len_d   = LEN_WIDTH'(1);
      end else begin
        e1 = 1'b1;
        t1 = '{ssl_pkg::KindError, '0, '0, line_a, ssl_pkg::ErrBadChar};
      end
    end
    mode_d = mode_a;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ssl_pkg::ModeIdle;
      pend_q  <= '0;
      pos_q   <= '0;
      begin_q <= '0;
      line_q  <= LINE_WIDTH'(1);
      len_q   <= '0;
    end else if (accept) begin
      mode_q  <= mode_d;
      pend_q  <= pend_d;
      pos_q   <= pos_d;
      begin_q <= begin_d;
      line_q  <= line_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) prefix_q <= prefix_d;
  end

  logic [1:0] cnt_mid;
  logic [1:0] push_n;
  assign cnt_mid = cnt_q - {1'b0, pop};
  assign push_n  = accept ? ({1'b0, e0} + {1'b0, e1}) : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      last_q <= '0;
    end else begin
      cnt_q <= cnt_mid + push_n;
      if (accept && e0 && e1) begin
        last_q <= 2'b10;
      end else if (accept && (e0 || e1)) begin
        last_q[cnt_mid[0]] <= 1'b1;
      end else if (pop) begin
        last_q[0] <= last_q[1];
      end
    end
  end

  // when pushing, cnt_mid is 0 so a pair fills both entries
  always_ff @(posedge clk_i) begin
    if (accept && e0 && e1) begin
      buf_q[0] <= t0;
      buf_q[1] <= t1;
    end else if (accept && e0) begin
      buf_q[cnt_mid[0]] <= t0;
    end else if (accept && e1) begin
      buf_q[cnt_mid[0]] <= t1;
    end else if (pop) begin
      buf_q[0] <= buf_q[1];
    end
  end

  assign tok_valid_o   = cnt_q != 2'd0;
  assign tok_kind_o    = buf_q[0].kind;
  assign tok_start_o   = buf_q[0].start;
  assign tok_length_o  = buf_q[0].len;
  assign tok_line_o    = buf_q[0].line;
  assign err_code_o    = buf_q[0].err;
  assign last_of_run_o = last_q[0];

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("output buffer overflow");
  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !src_ready_o) else $error("accept with full buffer");
  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0) else $error("line count reached zero");
  a_pair_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !last_q[0] || last_q[1]) else $error("pair order broken");
`endif

endmodule
`default_nettype wire
